>>> sv/mavg_pkg.sv
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared widths, register map, codes and structs of the moving-average block
// ----------------------------------------------------------------------------
`default_nettype none

package mavg_pkg;

    // field widths
    localparam int SAMPLE_W = 32;
    localparam int SLOT_W   = 6;
    localparam int LEN_W    = 7;
    localparam int SUM_W    = 38;
    localparam int CNT_W    = $clog2(SUM_W);

    // configuration port
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // register indexes
    localparam logic REG_WINDOW_LEN = 1'b0;

    // reset value of the window length
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);

    // saturation limits of the average
    localparam logic [SAMPLE_W-1:0] AVG_MAX = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] AVG_MIN = 32'h8000_0000;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [SLOT_W-1:0]          t_slot;
    typedef logic [LEN_W-1:0]           t_len;
    typedef logic signed [SUM_W-1:0]    t_sum;

    // divider request and response
    typedef struct packed {
        logic start;
        t_sum dividend;
        t_len divisor;
    } t_div_req;

    typedef struct packed {
        logic    done;
        t_sample quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

>>> sv/mavg_if.sv
// ----------------------------------------------------------------------------
// mavg_if
// Valid/ready channels for samples in and averages out
// ----------------------------------------------------------------------------
`default_nettype none

interface mavg_in_if;
    logic              valid;
    logic              ready;
    mavg_pkg::t_sample sample;
    mavg_pkg::t_slot   slot;

    modport source (output valid, output sample, output slot, input ready);
    modport sink   (input valid, input sample, input slot, output ready);
endinterface

interface mavg_out_if;
    logic              valid;
    logic              ready;
    mavg_pkg::t_sample average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

`default_nettype wire

>>> sv/moving_average_window_core.sv
// ----------------------------------------------------------------------------
// moving_average_window_core
// Moving average over a window store: updates the running sum, then divides
// ----------------------------------------------------------------------------
// One request at a time: a new one is accepted only when the sequencer is idle again.
// The 38-step shared divider sets the pace, one quotient bit per cycle.
// Reset: running sum zero, all store entries read as zero, window_len 8.
// A finished average waits in the output register while the next request runs.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_window_core #(
    parameter int WINDOW_DEPTH = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    mavg_in_if.sink                          i_in,
    mavg_out_if.source                       o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mavg_pkg::APB_AW-1:0] paddr,
    input  wire logic [mavg_pkg::APB_DW-1:0] pwdata,
    output logic      [mavg_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_DIVST = 3'd2;
    localparam logic [2:0] S_DIVW  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]             r_state;
    logic [2:0]             n_state;
    mavg_pkg::t_sample      r_sample;
    logic [AW-1:0]          r_pos;
    mavg_pkg::t_sum         r_sum;
    mavg_pkg::t_sample      r_avg;
    logic                   r_out_valid;
    mavg_pkg::t_sample      r_out_avg;

    logic                   in_acc;
    logic                   out_free;
    logic [mavg_pkg::SLOT_W-1:0] slot_red;
    logic [AW-1:0]          pos;
    mavg_pkg::t_sample      old_sample;
    mavg_pkg::t_len         window_len;
    mavg_pkg::t_div_req     div_req;
    mavg_pkg::t_div_rsp     div_rsp;

    mavg_cfg_regs u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_window_len (window_len)
    );

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;

    // slot modulo store depth, conditional subtract of shifted depth
    always_comb begin
        slot_red = i_in.slot;
        for (int k = mavg_pkg::SLOT_W - 1; k >= 0; k--) begin
            if (int'(slot_red) >= (WINDOW_DEPTH << k)) begin
                slot_red = slot_red - mavg_pkg::SLOT_W'(WINDOW_DEPTH << k);
            end
        end
    end
    assign pos = AW'(slot_red);

    mavg_store #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (pos),
        .i_wr_en   (r_state == S_SUM),
        .i_wr_addr (r_pos),
        .i_wr_data (r_sample),
        .o_rd_data (old_sample)
    );

    // divider request
    assign div_req.start    = (r_state == S_DIVST);
    assign div_req.dividend = r_sum;
    assign div_req.divisor  = window_len;

    mavg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_SUM;
            end
            S_SUM:   n_state = S_DIVST;
            S_DIVST: n_state = S_DIVW;
            S_DIVW: begin
                if (div_rsp.done) n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SUM) begin
                r_sum <= r_sum - mavg_pkg::SUM_W'(old_sample) + mavg_pkg::SUM_W'(r_sample);
            end
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_in.sample;
            r_pos    <= pos;
        end
        if (div_rsp.done) begin
            r_avg <= div_rsp.quotient;
        end
        if (r_state == S_FIN && out_free) begin
            r_out_avg <= r_avg;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.average = r_out_avg;

    // a request always moves on to the sum update
    a_acc_to_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SUM))
        else $error("request did not start the sum update");

    // divider finishes only while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIVW))
        else $error("divider done outside the wait state");

    // a held result is never overwritten
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && !o_out.ready) |=> (r_state == S_FIN))
        else $error("result left while output register was full");

    // running sum changes only on the update step
    a_sum_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SUM) |=> $stable(r_sum))
        else $error("running sum changed outside the update step");

endmodule

`default_nettype wire

>>> sv/mavg_cfg_regs.sv
// ----------------------------------------------------------------------------
// mavg_cfg_regs
// APB register file holding the window length
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mavg_pkg::APB_AW-1:0]   paddr,
    input  wire logic [mavg_pkg::APB_DW-1:0]   pwdata,
    output logic      [mavg_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output mavg_pkg::t_len                     o_window_len
);

    logic           wr_hit;
    mavg_pkg::t_len r_len;

    // register index is the word address
    assign wr_hit = psel && penable && pwrite && (paddr[2] == mavg_pkg::REG_WINDOW_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= mavg_pkg::LEN_RESET;
        end else if (wr_hit) begin
            r_len <= pwdata[mavg_pkg::LEN_W-1:0];
        end
    end

    // read back, unknown addresses read zero
    always_comb begin
        prdata = '0;
        if (paddr[2] == mavg_pkg::REG_WINDOW_LEN) begin
            prdata = mavg_pkg::APB_DW'(r_len);
        end
    end

    assign pready       = 1'b1;
    assign o_window_len = r_len;

endmodule

`default_nettype wire

>>> sv/mavg_store.sv
// ----------------------------------------------------------------------------
// mavg_store
// Window sample memory with per-entry valid bits, empty entries read zero
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [AW-1:0]     i_rd_addr,
    input  wire logic              i_wr_en,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire mavg_pkg::t_sample i_wr_data,
    output mavg_pkg::t_sample      o_rd_data
);

    mavg_pkg::t_sample mem [0:DEPTH-1];
    mavg_pkg::t_sample r_rd_q;
    logic [DEPTH-1:0]  r_vld;
    logic              r_rd_vld;

    // sample memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q <= mem[i_rd_addr];
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_q : '0;

endmodule

`default_nettype wire

>>> sv/mavg_div.sv
// ----------------------------------------------------------------------------
// mavg_div
// Restoring signed divider, one quotient bit per cycle, saturating result
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mavg_pkg::t_div_req i_req,
    output mavg_pkg::t_div_rsp      o_rsp
);

    localparam logic [mavg_pkg::CNT_W-1:0] LAST_STEP = mavg_pkg::CNT_W'(mavg_pkg::SUM_W - 1);
    localparam logic [mavg_pkg::SUM_W-1:0] POS_LIMIT = mavg_pkg::SUM_W'(32'h7FFF_FFFF);
    localparam logic [mavg_pkg::SUM_W-1:0] NEG_LIMIT = mavg_pkg::SUM_W'(32'h8000_0000);

    logic                         r_busy;
    logic                         r_done;
    logic [mavg_pkg::CNT_W-1:0]   r_cnt;
    logic                         r_neg;
    logic [mavg_pkg::SUM_W-1:0]   r_q;
    logic [mavg_pkg::LEN_W-1:0]   r_rem;
    logic [mavg_pkg::LEN_W-1:0]   r_dv;

    logic [mavg_pkg::SUM_W-1:0]   abs_in;
    logic [mavg_pkg::LEN_W:0]     trial;
    logic                         q_bit;
    logic [mavg_pkg::LEN_W-1:0]   n_rem;
    logic [mavg_pkg::SAMPLE_W-1:0] sat_q;

    // magnitude of the dividend
    assign abs_in = i_req.dividend[mavg_pkg::SUM_W-1] ? (~i_req.dividend + 1'b1)
                                                       : i_req.dividend;

    // one restoring step
    assign trial = {r_rem, r_q[mavg_pkg::SUM_W-1]};
    assign q_bit = (trial >= {1'b0, r_dv});
    always_comb begin
        n_rem = trial[mavg_pkg::LEN_W-1:0];
        if (q_bit) begin
            n_rem = mavg_pkg::LEN_W'(trial - {1'b0, r_dv});
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, zero length divides by one
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[mavg_pkg::SUM_W-1];
            r_q   <= abs_in;
            r_rem <= '0;
            r_dv  <= (i_req.divisor == '0) ? mavg_pkg::LEN_W'(1) : i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[mavg_pkg::SUM_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    // sign and saturation of the quotient
    always_comb begin
        if (r_neg) begin
            if (r_q > NEG_LIMIT) begin
                sat_q = mavg_pkg::AVG_MIN;
            end else begin
                sat_q = ~r_q[mavg_pkg::SAMPLE_W-1:0] + 1'b1;
            end
        end else begin
            if (r_q > POS_LIMIT) begin
                sat_q = mavg_pkg::AVG_MAX;
            end else begin
                sat_q = r_q[mavg_pkg::SAMPLE_W-1:0];
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = sat_q;

endmodule

`default_nettype wire
